@@ src/cwe_pkg.sv @@
// codebook word encoder package: sequencer states, action codes, field widths
// and packing offsets of the stream words
// no dependencies
package cwe_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_ENCODE = 2'd2,
        ACT_TENSOR = 2'd3
    } action_t;

    localparam int WORD_W       = 32;
    localparam int CODE_W       = 12;
    localparam int CODE_BYTES_W = 2;
    localparam int POS_W        = 32;
    localparam int HITS_W       = 32;

    localparam int OUT_DATA_W   = 112;
    localparam int CODE_LSB     = 0;
    localparam int BYTES_LSB    = CODE_LSB + CODE_W;
    localparam int MISS_LSB     = BYTES_LSB + CODE_BYTES_W;
    localparam int POS_LSB      = MISS_LSB + WORD_W;
    localparam int HITS_LSB     = POS_LSB + POS_W;
    localparam int PAD_W        = OUT_DATA_W - (HITS_LSB + HITS_W);

    localparam logic [31:0] ONE_BYTE_MAX_ENTRIES = 32'd256;
    localparam logic [CODE_BYTES_W-1:0] ONE_BYTE  = 2'd1;
    localparam logic [CODE_BYTES_W-1:0] TWO_BYTES = 2'd2;

endpackage

@@ src/codebook_word_encoder_core.sv @@
// codebook word encoder: codebook memory with a linear search sequencer,
// hit and position counters and a registered result word
// depends on cwe_pkg
//
// load, clear and new-tensor words leave the sequencer idle and give no result
// an encode word is searched one codebook entry per cycle from the single read port;
// its result word is registered from the emit state once the search stops at the first
// matching code or passes the last entry (an empty codebook skips the search), waiting there
// while the output register holds an unaccepted word; the next word can be taken from then on
// reset clears counters and control; codebook contents are undefined until loaded
module codebook_word_encoder_core #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // word
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // code, code_bytes, miss_word, position, hit_count, zero pad
    output logic         m_tuser    // is_hit
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    logic [cwe_pkg::WORD_W-1:0] mem [TABLE_ENTRIES];
    logic [cwe_pkg::WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]           rd_addr;
    logic                       mem_we;

    cwe_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [cwe_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [cwe_pkg::HITS_W-1:0] hits_reg, hits_next;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [cwe_pkg::WORD_W-1:0] word_reg, word_next;
    logic                       res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]           res_idx_reg, res_idx_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_hit_reg, out_hit_next;
    logic [cwe_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    cwe_pkg::action_t           s_action;
    logic                       s_fire;
    logic                       out_free;
    logic [cwe_pkg::CODE_BYTES_W-1:0] code_bytes;
    logic [cwe_pkg::HITS_W-1:0] hits_inc;

    assign s_action = cwe_pkg::action_t'(s_tuser);
    assign s_tready = (state_reg == cwe_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign rd_addr  = issue_reg[IDX_W-1:0];
    assign mem_we   = s_fire && (s_action == cwe_pkg::ACT_LOAD) && (count_reg < CNT_FULL);

    assign code_bytes = (32'(count_reg) <= cwe_pkg::ONE_BYTE_MAX_ENTRIES) ?
                        cwe_pkg::ONE_BYTE : cwe_pkg::TWO_BYTES;
    assign hits_inc   = hits_reg + cwe_pkg::HITS_W'(res_hit_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[IDX_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        hits_next      = hits_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        word_next      = word_reg;
        res_hit_next   = res_hit_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_hit_next   = out_hit_reg;
        out_data_next  = out_data_reg;

        case (state_reg)
            cwe_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_action)
                        cwe_pkg::ACT_CLEAR: begin
                            count_next = '0;
                            pos_next   = '0;
                            hits_next  = '0;
                        end
                        cwe_pkg::ACT_LOAD: begin
                            if (count_reg < CNT_FULL) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        cwe_pkg::ACT_TENSOR: begin
                            pos_next  = '0;
                            hits_next = '0;
                        end
                        cwe_pkg::ACT_ENCODE: begin
                            word_next    = s_tdata;
                            issue_next   = '0;
                            res_hit_next = 1'b0;
                            res_idx_next = '0;
                            state_next   = (count_reg == '0) ? cwe_pkg::ST_EMIT
                                                             : cwe_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cwe_pkg::ST_SCAN: begin
                // compare the entry read last cycle while the next read goes out
                if (cmp_valid_reg && (rd_data_reg == word_reg)) begin
                    res_hit_next = 1'b1;
                    res_idx_next = cmp_idx_reg;
                    state_next   = cwe_pkg::ST_EMIT;
                end else if (issue_reg < count_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end else begin
                    res_hit_next = 1'b0;
                    state_next   = cwe_pkg::ST_EMIT;
                end
            end
            cwe_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_data_next  = {
                        {cwe_pkg::PAD_W{1'b0}},
                        hits_inc,
                        pos_reg,
                        res_hit_reg ? {cwe_pkg::WORD_W{1'b0}} : word_reg,
                        code_bytes,
                        res_hit_reg ? cwe_pkg::CODE_W'(res_idx_reg) : {cwe_pkg::CODE_W{1'b0}}
                    };
                    hits_next  = hits_inc;
                    pos_next   = pos_reg + cwe_pkg::POS_W'(1);
                    state_next = cwe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cwe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cwe_pkg::ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            hits_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            hits_reg      <= hits_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg    <= issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        word_reg     <= word_next;
        res_hit_reg  <= res_hit_next;
        res_idx_reg  <= res_idx_next;
        out_hit_reg  <= out_hit_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ tb/sv/codebook_word_encoder_core_test.sv @@
// codebook word encoder testbench: directed and random words through the stream ports,
// results checked against a predicted codebook search held in a scoreboard class
// depends on cwe_pkg and codebook_word_encoder_core

typedef struct {
    logic                             hit;
    logic [cwe_pkg::CODE_W-1:0]       code;
    logic [cwe_pkg::CODE_BYTES_W-1:0] nbytes;
    logic [cwe_pkg::WORD_W-1:0]       miss_word;
    logic [cwe_pkg::POS_W-1:0]        position;
    logic [cwe_pkg::HITS_W-1:0]       hits;
} encode_result_t;

class encode_scoreboard #(int DEPTH = 4096);
    logic [cwe_pkg::WORD_W-1:0] book [DEPTH];
    int unsigned                book_count;
    logic [cwe_pkg::POS_W-1:0]  next_position;
    logic [cwe_pkg::HITS_W-1:0] tensor_hits;
    encode_result_t             awaited [$];
    int unsigned                mismatches;

    function new();
        book_count = 0;
        next_position = '0;
        tensor_hits = '0;
        mismatches = 0;
    endfunction

    function void note_word(cwe_pkg::action_t act, logic [cwe_pkg::WORD_W-1:0] w);
        encode_result_t r;
        int unsigned i;
        case (act)
            cwe_pkg::ACT_CLEAR: begin
                book_count = 0;
                next_position = '0;
                tensor_hits = '0;
            end
            cwe_pkg::ACT_LOAD: begin
                if (book_count < DEPTH) begin
                    book[book_count] = w;
                    book_count++;
                end
            end
            cwe_pkg::ACT_TENSOR: begin
                next_position = '0;
                tensor_hits = '0;
            end
            cwe_pkg::ACT_ENCODE: begin
                r.hit = 1'b0;
                r.code = '0;
                // lowest matching code wins on duplicates
                for (i = 0; i < book_count; i++) begin
                    if (book[i] == w) begin
                        r.hit = 1'b1;
                        r.code = cwe_pkg::CODE_W'(i);
                        break;
                    end
                end
                if (r.hit) tensor_hits++;
                r.nbytes = (book_count <= cwe_pkg::ONE_BYTE_MAX_ENTRIES) ?
                           cwe_pkg::ONE_BYTE : cwe_pkg::TWO_BYTES;
                r.miss_word = r.hit ? '0 : w;
                r.position = next_position;
                r.hits = tensor_hits;
                next_position++;
                awaited = {awaited, r};
            end
            default: begin
            end
        endcase
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) flag($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void check_result(logic hit, logic [cwe_pkg::OUT_DATA_W-1:0] data);
        encode_result_t e;
        if (awaited.size() == 0) begin
            flag("result word with none pending");
            return;
        end
        e = awaited.pop_front();
        compare_field("is_hit", 32'(e.hit), 32'(hit));
        compare_field("code", 32'(e.code),
                      32'(data[cwe_pkg::CODE_LSB +: cwe_pkg::CODE_W]));
        compare_field("code_bytes", 32'(e.nbytes),
                      32'(data[cwe_pkg::BYTES_LSB +: cwe_pkg::CODE_BYTES_W]));
        compare_field("miss_word", e.miss_word, data[cwe_pkg::MISS_LSB +: cwe_pkg::WORD_W]);
        compare_field("position", e.position, data[cwe_pkg::POS_LSB +: cwe_pkg::POS_W]);
        compare_field("hit_count", e.hits, data[cwe_pkg::HITS_LSB +: cwe_pkg::HITS_W]);
        compare_field("pad", '0,
                      32'(data[cwe_pkg::OUT_DATA_W-1:cwe_pkg::HITS_LSB+cwe_pkg::HITS_W]));
    endfunction
endclass

module codebook_word_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOOK_DEPTH   = 4096;
    localparam int RANDOM_WORDS = 1350;
    localparam int STALL_LIMIT  = 50000;
    localparam int SETTLE       = 20;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [cwe_pkg::WORD_W-1:0]     s_tdata  = '0;
    logic [1:0]                     s_tuser  = cwe_pkg::ACT_CLEAR;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cwe_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;

    encode_scoreboard #(BOOK_DEPTH) book_sb;
    logic [cwe_pkg::WORD_W-1:0] pool [$];
    int unsigned       burst_left   = 0;
    int unsigned       words_sent   = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       ready_span   = 0;
    rx_mode_t          ready_mode   = RX_OPEN;

    codebook_word_encoder_core #(
        .TABLE_ENTRIES(BOOK_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_span <= $urandom_range(20, 300);
            ready_mode <= rx_mode_t'($urandom_range(0, 3));
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= ~m_tready;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) book_sb.note_word(cwe_pkg::action_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) book_sb.check_result(m_tuser, m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_word(input cwe_pkg::action_t act,
                             input logic [cwe_pkg::WORD_W-1:0] w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        burst_left--;
        words_sent++;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (book_sb.awaited.size() != 0) @(posedge aclk);
    endtask

    // mostly fresh entries, some duplicates of earlier ones
    task automatic load_word();
        logic [cwe_pkg::WORD_W-1:0] w;
        if (pool.size() != 0 && $urandom_range(0, 15) == 0) begin
            w = pool[$urandom_range(0, pool.size() - 1)];
        end else begin
            w = $urandom();
        end
        send_word(cwe_pkg::ACT_LOAD, w);
        if (pool.size() < BOOK_DEPTH) pool = {pool, w};
    endtask

    task automatic run_phase(input int unsigned book_size, input int unsigned steps);
        int unsigned pick;
        send_word(cwe_pkg::ACT_CLEAR, $urandom());
        pool.delete();
        repeat (book_size) load_word();
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 68 && pool.size() != 0) begin
                send_word(cwe_pkg::ACT_ENCODE, pool[$urandom_range(0, pool.size() - 1)]);
            end else if (pick < 88) begin
                send_word(cwe_pkg::ACT_ENCODE, $urandom());
            end else if (pick < 94) begin
                send_word(cwe_pkg::ACT_TENSOR, $urandom());
            end else if (pick < 98) begin
                load_word();
            end else begin
                send_word(cwe_pkg::ACT_CLEAR, $urandom());
                pool.delete();
            end
        end
    endtask

    initial begin
        int unsigned phase;

        book_sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty codebook misses, then a small codebook with a duplicate entry, new tensor and clear
        send_word(cwe_pkg::ACT_ENCODE, 32'h0000_0000);
        send_word(cwe_pkg::ACT_ENCODE, 32'hffff_ffff);
        send_word(cwe_pkg::ACT_LOAD, 32'h0000_0000);
        send_word(cwe_pkg::ACT_LOAD, 32'hffff_ffff);
        send_word(cwe_pkg::ACT_LOAD, 32'h3f80_0000);
        send_word(cwe_pkg::ACT_LOAD, 32'h3f80_0000);
        send_word(cwe_pkg::ACT_LOAD, 32'h8000_0000);
        send_word(cwe_pkg::ACT_ENCODE, 32'hffff_ffff);
        send_word(cwe_pkg::ACT_ENCODE, 32'h3f80_0000);
        send_word(cwe_pkg::ACT_ENCODE, 32'h8000_0000);
        send_word(cwe_pkg::ACT_ENCODE, 32'h7fff_ffff);
        send_word(cwe_pkg::ACT_ENCODE, 32'h0000_0000);
        send_word(cwe_pkg::ACT_TENSOR, 32'h0000_0000);
        send_word(cwe_pkg::ACT_ENCODE, 32'h3f80_0000);
        send_word(cwe_pkg::ACT_ENCODE, 32'h5555_aaaa);
        wait_results_done();
        send_word(cwe_pkg::ACT_CLEAR, 32'hffff_ffff);
        send_word(cwe_pkg::ACT_ENCODE, 32'h3f80_0000);
        send_word(cwe_pkg::ACT_LOAD, 32'haaaa_5555);
        send_word(cwe_pkg::ACT_ENCODE, 32'haaaa_5555);

        phase = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (phase % 9 == 3) begin
                run_phase(256, 24);
            end else if (phase % 9 == 7) begin
                run_phase(257, 24);
            end else if ($urandom_range(0, 7) == 0) begin
                run_phase(0, $urandom_range(10, 30));
            end else begin
                run_phase($urandom_range(1, 40), $urandom_range(20, 80));
            end
            if ($urandom_range(0, 2) == 0) wait_results_done();
            phase++;
        end

        wait_results_done();
        repeat (SETTLE) @(posedge aclk);
        if (book_sb.mismatches == 0 && book_sb.awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ codebook_word_encoder_core.f @@
src/cwe_pkg.sv
src/codebook_word_encoder_core.sv
tb/sv/codebook_word_encoder_core_test.sv
